### src/rosi_pkg.sv
// ----------------------------------------------------------------------------
// rosi_pkg
// Shared constants and types for the ray versus oriented box slab test.
// ----------------------------------------------------------------------------
package rosi_pkg;

    localparam int COORD_W_DEF = 20;
    localparam int DIR_W       = 16;
    localparam int NUM_AXES    = 3;
    localparam int DOT_W       = 2 * DIR_W + 2;
    localparam int DIST_W      = 32;
    localparam int QUO_BITS    = DIST_W - 1;
    localparam int DIV_LAT     = QUO_BITS + 3;
    localparam int DOT_LAT     = 3;
    localparam int SLAB_LAT    = 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [DIST_W-1:0] DIST_SENT = 32'sh7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_AXIS_U  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_AXIS_V  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_AXIS_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALVES  = 3'd4;

    typedef struct packed {
        logic [NUM_AXES-1:0] dzero;
        logic [NUM_AXES-1:0] outside;
    } slab_flags_t;

endpackage

### src/rosi_dot.sv
// ----------------------------------------------------------------------------
// rosi_dot
// Three stage dot product front end: offset, products, sums per box axis.
// ----------------------------------------------------------------------------
module rosi_dot #(
    parameter int COORD_WIDTH = rosi_pkg::COORD_W_DEF
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [3*COORD_WIDTH-1:0]                center,
    input  logic [3*rosi_pkg::DIR_W-1:0]            axis [rosi_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]           start [3],
    input  logic signed [rosi_pkg::DIR_W-1:0]       dir [3],
    output logic signed [COORD_WIDTH+rosi_pkg::DIR_W+2:0] s_dot [rosi_pkg::NUM_AXES],
    output logic signed [rosi_pkg::DOT_W-1:0]       d_dot [rosi_pkg::NUM_AXES]
);

    localparam int PW  = COORD_WIDTH + 1;
    localparam int PRW = rosi_pkg::DIR_W + PW;
    localparam int SW  = PRW + 2;
    localparam int DPW = 2 * rosi_pkg::DIR_W;
    localparam int NA  = rosi_pkg::NUM_AXES;

    logic signed [PW-1:0]                 p_reg [3];
    logic signed [PW-1:0]                 p_next [3];
    logic signed [rosi_pkg::DIR_W-1:0]    dir_reg [3];
    logic signed [PRW-1:0]                ps_reg [NA][3];
    logic signed [PRW-1:0]                ps_next [NA][3];
    logic signed [DPW-1:0]                pd_reg [NA][3];
    logic signed [DPW-1:0]                pd_next [NA][3];
    logic signed [SW-1:0]                 s_reg [NA];
    logic signed [rosi_pkg::DOT_W-1:0]    d_reg [NA];
    logic signed [rosi_pkg::DIR_W-1:0]    a_comp [NA][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_next[k] = PW'($signed(center[k*COORD_WIDTH +: COORD_WIDTH])) - PW'(start[k]);
        end
        for (int i = 0; i < NA; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_comp[i][k]  = $signed(axis[i][k*rosi_pkg::DIR_W +: rosi_pkg::DIR_W]);
                ps_next[i][k] = PRW'(a_comp[i][k]) * PRW'(p_reg[k]);
                pd_next[i][k] = DPW'(a_comp[i][k]) * DPW'(dir_reg[k]);
            end
        end
    end

    // offset, then products, then sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k]   <= p_next[k];
                dir_reg[k] <= dir[k];
            end
            for (int i = 0; i < NA; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ps_reg[i][k] <= ps_next[i][k];
                    pd_reg[i][k] <= pd_next[i][k];
                end
                s_reg[i] <= SW'(ps_reg[i][0]) + SW'(ps_reg[i][1]) + SW'(ps_reg[i][2]);
                d_reg[i] <= rosi_pkg::DOT_W'(pd_reg[i][0]) + rosi_pkg::DOT_W'(pd_reg[i][1])
                          + rosi_pkg::DOT_W'(pd_reg[i][2]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            s_dot[i] = s_reg[i];
            d_dot[i] = d_reg[i];
        end
    end

endmodule

### src/rosi_div.sv
// ----------------------------------------------------------------------------
// rosi_div
// Pipelined restoring divider, one quotient bit per stage, truncates toward
// zero and saturates to the distance sentinels.
// ----------------------------------------------------------------------------
module rosi_div #(
    parameter int NUM_W = rosi_pkg::COORD_W_DEF + 34
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [NUM_W-1:0]              num,
    input  logic signed [rosi_pkg::DOT_W-1:0]    den,
    output logic signed [rosi_pkg::DIST_W-1:0]   quo
);

    localparam int DW = rosi_pkg::DOT_W;
    localparam int W  = NUM_W + DW;
    localparam int QB = rosi_pkg::QUO_BITS;

    logic [W-1:0]               nmag_reg;
    logic [DW-1:0]              dmag_reg;
    logic                       neg_reg;
    logic [W-1:0]               rem_reg  [QB+1];
    logic [QB-1:0]              q_reg    [QB+1];
    logic [DW-1:0]              dm_reg   [QB+1];
    logic                       ovf_reg  [QB+1];
    logic                       sgn_reg  [QB+1];
    logic signed [rosi_pkg::DIST_W-1:0] quo_reg;
    logic signed [rosi_pkg::DIST_W-1:0] mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg   <= num[NUM_W-1] ? -W'(num) : W'(num);
            dmag_reg   <= den[DW-1] ? -den : den;
            neg_reg    <= num[NUM_W-1] ^ den[DW-1];
            rem_reg[0] <= nmag_reg;
            q_reg[0]   <= '0;
            dm_reg[0]  <= dmag_reg;
            ovf_reg[0] <= nmag_reg >= (W'(dmag_reg) << QB);
            sgn_reg[0] <= neg_reg;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_stage
        localparam int B = QB - j;
        logic [W-1:0] shd;
        logic         take;
        assign shd  = W'(dm_reg[j-1]) << B;
        assign take = rem_reg[j-1] >= shd;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= take ? rem_reg[j-1] - shd : rem_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (take ? (QB'(1) << B) : '0);
                dm_reg[j]  <= dm_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                sgn_reg[j] <= sgn_reg[j-1];
            end
        end
    end

    assign mag = ovf_reg[QB] ? rosi_pkg::DIST_SENT : $signed({1'b0, q_reg[QB]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= sgn_reg[QB] ? -mag : mag;
        end
    end

    assign quo = quo_reg;

endmodule

### src/rosi_slab.sv
// ----------------------------------------------------------------------------
// rosi_slab
// Orders slab distances, narrows the interval and picks the hit distance.
// ----------------------------------------------------------------------------
module rosi_slab #(
    parameter int COORD_WIDTH = rosi_pkg::COORD_W_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [rosi_pkg::DIST_W-1:0]   q_a [rosi_pkg::NUM_AXES],
    input  logic signed [rosi_pkg::DIST_W-1:0]   q_b [rosi_pkg::NUM_AXES],
    input  rosi_pkg::slab_flags_t                flags,
    input  logic [COORD_WIDTH-1:0]               len,
    output logic                                 hit,
    output logic signed [rosi_pkg::DIST_W-1:0]   hit_dist
);

    localparam int NA = rosi_pkg::NUM_AXES;
    localparam int DW = rosi_pkg::DIST_W;

    logic signed [DW-1:0]   lo_reg [NA];
    logic signed [DW-1:0]   hi_reg [NA];
    rosi_pkg::slab_flags_t  flags_reg;
    logic [COORD_WIDTH-1:0] len_a_reg;
    logic [COORD_WIDTH-1:0] len_b_reg;
    logic signed [DW-1:0]   first_reg;
    logic signed [DW-1:0]   last_reg;
    logic                   fail_reg;
    logic signed [DW-1:0]   first_next;
    logic signed [DW-1:0]   last_next;
    logic signed [DW-1:0]   t;
    logic                   ok;

    always_comb
    begin
        first_next = -rosi_pkg::DIST_SENT;
        last_next  = rosi_pkg::DIST_SENT;
        for (int i = 0; i < NA; i++)
        begin
            if (!flags_reg.dzero[i])
            begin
                if (lo_reg[i] > first_next)
                begin
                    first_next = lo_reg[i];
                end
                if (hi_reg[i] < last_next)
                begin
                    last_next = hi_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                lo_reg[i] <= (q_a[i] > q_b[i]) ? q_b[i] : q_a[i];
                hi_reg[i] <= (q_a[i] > q_b[i]) ? q_a[i] : q_b[i];
            end
            flags_reg <= flags;
            len_a_reg <= len;
            first_reg <= first_next;
            last_reg  <= last_next;
            fail_reg  <= |(flags_reg.dzero & flags_reg.outside);
            len_b_reg <= len_a_reg;
        end
    end

    assign ok       = !fail_reg && (first_reg <= last_reg);
    assign t        = (first_reg > 0) ? first_reg : last_reg;
    assign hit      = ok && ((DW+1)'(t) <= $signed((DW+1)'(len_b_reg)));
    assign hit_dist = ok ? t : '0;

endmodule

### src/ray_obb_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_obb_slab_intersect_core
// Ray versus oriented box test by the slab method in fixed point.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   input    | in_valid / in_stall  | ray_start_x/y/z, ray_dir_x/y/z, ray_length
//   output   | out_valid / out_stall| hit, hit_distance
//   config   | cfg_we               | cfg_index, cfg_data
//
// one item per cycle while no result is held under out_stall; the dividers
// resolve one quotient bit per stage (31 quotient bits plus setup and sign stages)
// reset clears the valid bits and the box registers but not the hit and distance registers
// the whole pipeline holds while a result waits under out_stall
// ----------------------------------------------------------------------------
module ray_obb_slab_intersect_core #(
    parameter int COORD_WIDTH = rosi_pkg::COORD_W_DEF,
    parameter int CFG_W = (3 * COORD_WIDTH > 3 * rosi_pkg::DIR_W) ?
                          3 * COORD_WIDTH : 3 * rosi_pkg::DIR_W
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rosi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]                     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        ray_start_x,
    input  logic signed [COORD_WIDTH-1:0]        ray_start_y,
    input  logic signed [COORD_WIDTH-1:0]        ray_start_z,
    input  logic signed [rosi_pkg::DIR_W-1:0]    ray_dir_x,
    input  logic signed [rosi_pkg::DIR_W-1:0]    ray_dir_y,
    input  logic signed [rosi_pkg::DIR_W-1:0]    ray_dir_z,
    input  logic [COORD_WIDTH-1:0]               ray_length,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic signed [rosi_pkg::DIST_W-1:0]   hit_distance
);

    localparam int NA      = rosi_pkg::NUM_AXES;
    localparam int SW      = COORD_WIDTH + rosi_pkg::DIR_W + 3;
    localparam int NUM_W   = COORD_WIDTH + 34;
    localparam int CMP_W   = SW + 1;
    localparam int LEN_LAT = rosi_pkg::DOT_LAT + rosi_pkg::DIV_LAT;
    localparam int V_LAT   = LEN_LAT + rosi_pkg::SLAB_LAT;

    logic [3*COORD_WIDTH-1:0]          center_reg;
    logic [3*rosi_pkg::DIR_W-1:0]      axis_reg [NA];
    logic [3*COORD_WIDTH-1:0]          halves_reg;

    logic                              en;
    logic [V_LAT-1:0]                  vld_reg;
    logic                              out_valid_reg;
    logic                              hit_reg;
    logic signed [rosi_pkg::DIST_W-1:0] dist_reg;
    logic [COORD_WIDTH-1:0]            len_reg [LEN_LAT];
    rosi_pkg::slab_flags_t             flags_reg [rosi_pkg::DIV_LAT];
    rosi_pkg::slab_flags_t             flags_next;

    logic signed [COORD_WIDTH-1:0]     start [3];
    logic signed [rosi_pkg::DIR_W-1:0] dir [3];
    logic signed [SW-1:0]              s_dot [NA];
    logic signed [rosi_pkg::DOT_W-1:0] d_dot [NA];
    logic signed [NUM_W-1:0]           num_a [NA];
    logic signed [NUM_W-1:0]           num_b [NA];
    logic signed [CMP_W-1:0]           hls [NA];
    logic signed [rosi_pkg::DIST_W-1:0] q_a [NA];
    logic signed [rosi_pkg::DIST_W-1:0] q_b [NA];
    logic                              slab_hit;
    logic signed [rosi_pkg::DIST_W-1:0] slab_dist;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            halves_reg <= '0;
            for (int i = 0; i < NA; i++)
            begin
                axis_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rosi_pkg::CFG_BOX_CENTER: center_reg  <= cfg_data[3*COORD_WIDTH-1:0];
                rosi_pkg::CFG_BOX_AXIS_U: axis_reg[0] <= cfg_data[3*rosi_pkg::DIR_W-1:0];
                rosi_pkg::CFG_BOX_AXIS_V: axis_reg[1] <= cfg_data[3*rosi_pkg::DIR_W-1:0];
                rosi_pkg::CFG_BOX_AXIS_W: axis_reg[2] <= cfg_data[3*rosi_pkg::DIR_W-1:0];
                rosi_pkg::CFG_BOX_HALVES: halves_reg  <= cfg_data[3*COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign start[0] = ray_start_x;
    assign start[1] = ray_start_y;
    assign start[2] = ray_start_z;
    assign dir[0]   = ray_dir_x;
    assign dir[1]   = ray_dir_y;
    assign dir[2]   = ray_dir_z;

    rosi_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk    (clk),
        .en     (en),
        .center (center_reg),
        .axis   (axis_reg),
        .start  (start),
        .dir    (dir),
        .s_dot  (s_dot),
        .d_dot  (d_dot)
    );

    // slab numerators and zero-direction containment test
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            hls[i] = CMP_W'($signed({1'b0, halves_reg[i*COORD_WIDTH +: COORD_WIDTH]})) <<< 14;
            num_a[i] = NUM_W'(CMP_W'(s_dot[i]) + hls[i]) <<< 14;
            num_b[i] = NUM_W'(CMP_W'(s_dot[i]) - hls[i]) <<< 14;
            flags_next.dzero[i]   = d_dot[i] == '0;
            flags_next.outside[i] = (CMP_W'(s_dot[i]) < -hls[i]) || (CMP_W'(s_dot[i]) > hls[i]);
        end
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_axis
        rosi_div #(
            .NUM_W (NUM_W)
        ) u_div_a (
            .clk (clk),
            .en  (en),
            .num (num_a[i]),
            .den (d_dot[i]),
            .quo (q_a[i])
        );
        rosi_div #(
            .NUM_W (NUM_W)
        ) u_div_b (
            .clk (clk),
            .en  (en),
            .num (num_b[i]),
            .den (d_dot[i]),
            .quo (q_b[i])
        );
    end

    // side data travelling alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= ray_length;
            for (int j = 1; j < LEN_LAT; j++)
            begin
                len_reg[j] <= len_reg[j-1];
            end
            flags_reg[0] <= flags_next;
            for (int j = 1; j < rosi_pkg::DIV_LAT; j++)
            begin
                flags_reg[j] <= flags_reg[j-1];
            end
        end
    end

    rosi_slab #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_slab (
        .clk      (clk),
        .en       (en),
        .q_a      (q_a),
        .q_b      (q_b),
        .flags    (flags_reg[rosi_pkg::DIV_LAT-1]),
        .len      (len_reg[LEN_LAT-1]),
        .hit      (slab_hit),
        .hit_dist (slab_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[V_LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[V_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= slab_hit;
            dist_reg <= slab_dist;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;

`ifndef SYNTH
    // a full-range distance never lies within a ray length
    a_sent_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> hit_distance != rosi_pkg::DIST_SENT)
        else $error("hit reported at sentinel distance");

    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a miss reports zero or a nonnegative distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit && hit_distance != rosi_pkg::DIST_SENT |->
        hit_distance == '0 || hit_distance[rosi_pkg::DIST_W-1] == 1'b0)
        else $error("miss with negative nonzero distance");
`endif

endmodule
